@@ sv/bfpa_pkg.sv @@
// Shared types, sizes and field conversion helpers for the best-fit partition allocator.
// Depends on nothing; bfpa_select, the top level and the testbench import it.

package bfpa_pkg;

    // Table geometry.
    localparam int PARTITIONS = 16;
    localparam int SIZE_BITS  = 16;

    // Fixed widths of the transaction fields.
    localparam int FIELD_IDX_BITS  = 4;
    localparam int FIELD_SIZE_BITS = 16;
    localparam int CFG_BITS        = 5;

    // Derived widths: table address and a scan count that can hold PARTITIONS itself.
    localparam int IDX_BITS = $clog2(PARTITIONS);
    localparam int CNT_BITS = $clog2(PARTITIONS + 1);

    // Value of the partition count register after reset.
    localparam logic [CFG_BITS-1:0] CFG_RESET = CFG_BITS'(16);

    // Operation codes carried in the func field.
    localparam logic FUNC_LOAD    = 1'b0;
    localparam logic FUNC_REQUEST = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic                       func;
        logic [FIELD_IDX_BITS-1:0]  partition_index;
        logic [FIELD_SIZE_BITS-1:0] size;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic                      granted;
        logic [FIELD_IDX_BITS-1:0] block_index;
    } out_t;

    // One table entry presented to the best-fit tracker.
    typedef struct packed {
        logic                 vld;
        logic [IDX_BITS-1:0]  idx;
        logic [SIZE_BITS-1:0] have;
    } cand_t;

    // Size field to table width: low bits kept, zero-extended where the table is wider.
    function automatic logic [SIZE_BITS-1:0] fit_size(input logic [FIELD_SIZE_BITS-1:0] s);
        logic [SIZE_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < SIZE_BITS; i++) begin
            r[i] = (i < FIELD_SIZE_BITS) ? s[i % FIELD_SIZE_BITS] : 1'b0;
        end
        return r;
    endfunction

    // Index field to table address.
    function automatic logic [IDX_BITS-1:0] to_addr(input logic [FIELD_IDX_BITS-1:0] a);
        logic [IDX_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < IDX_BITS; i++) begin
            r[i] = (i < FIELD_IDX_BITS) ? a[i % FIELD_IDX_BITS] : 1'b0;
        end
        return r;
    endfunction

    // Table address to the result field: its low bits.
    function automatic logic [FIELD_IDX_BITS-1:0] to_field(input logic [IDX_BITS-1:0] a);
        logic [FIELD_IDX_BITS-1:0] r;
        r = '0;
        for (int i = 0; i < FIELD_IDX_BITS; i++) begin
            r[i] = (i < IDX_BITS) ? a[i % IDX_BITS] : 1'b0;
        end
        return r;
    endfunction

endpackage

@@ sv/bfpa_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.

module bfpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/bfpa_select.sv @@
// Best-fit tracker: keeps the smallest entry that still holds the request.
// Depends on bfpa_pkg.

module bfpa_select
    import bfpa_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 clear,
    input  cand_t                cand,
    input  logic [SIZE_BITS-1:0] req_size,
    output logic                 found,
    output logic [IDX_BITS-1:0]  best_idx
);

    logic                 found_reg, found_next;
    logic [IDX_BITS-1:0]  best_idx_reg, best_idx_next;
    logic [SIZE_BITS-1:0] best_have_reg, best_have_next;
    logic                 fits;
    logic                 better;

    // For a fixed request the smallest slack is the smallest fitting size, so the
    // stored sizes are compared directly. A strict compare keeps the lowest index on a tie.
    assign fits   = cand.vld && (cand.have >= req_size);
    assign better = fits && (!found_reg || (cand.have < best_have_reg));

    always_comb begin
        found_next     = found_reg;
        best_idx_next  = best_idx_reg;
        best_have_next = best_have_reg;
        if (clear) begin
            found_next    = 1'b0;
            best_idx_next = '0;
        end else if (better) begin
            found_next     = 1'b1;
            best_idx_next  = cand.idx;
            best_have_next = cand.have;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg    <= 1'b0;
            best_idx_reg <= '0;
        end else begin
            found_reg    <= found_next;
            best_idx_reg <= best_idx_next;
        end
        best_have_reg <= best_have_next;
    end

    assign found    = found_reg;
    assign best_idx = best_idx_reg;

endmodule

@@ sv/best_fit_partition_allocator.sv @@
// Top level of the best-fit partition allocator: sequencer, size table and result register.
// Depends on bfpa_pkg, bfpa_ram and bfpa_select.
//
//   Channel   Ports                        Direction  Moves
//   input     s_valid, s_ready, s_data     in         in_t: func, partition_index, size
//   result    m_valid, m_ready, m_data     out        out_t: granted, block_index
//   config    cfg_we, cfg_wdata            in         partitions_in_use, no wait
//
// A load writes the table and goes to the final step; a request scans N partitions (capped at
// PARTITIONS), one table read per cycle, and writes back the grant, if any, before that step.
// After reset all table entries read as zero through per-entry valid bits; no clear pass.
// A result waits in the output register while the next transaction is accepted; the
// sequencer only stalls at its final step when that register is still occupied.

module best_fit_partition_allocator
    import bfpa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  in_t                 s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output out_t                m_data,
    input  logic                cfg_we,
    input  logic [CFG_BITS-1:0] cfg_wdata
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_GRANT  = 4'b0100,
        ST_FINISH = 4'b1000
    } state_t;

    state_t                state_reg, state_next;
    logic [CFG_BITS-1:0]   cfg_reg, cfg_next;
    logic [PARTITIONS-1:0] valid_reg, valid_next;
    logic [CNT_BITS-1:0]   rd_cnt_reg, rd_cnt_next;
    logic [CNT_BITS-1:0]   lim_reg, lim_next;
    logic [SIZE_BITS-1:0]  req_size_reg, req_size_next;
    logic                  cmp_vld_reg, cmp_vld_next;
    logic [IDX_BITS-1:0]   cmp_idx_reg, cmp_idx_next;
    logic                  cmp_hit_reg, cmp_hit_next;
    logic                  m_valid_reg, m_valid_next;
    out_t                  m_data_reg, m_data_next;

    logic                  accept;
    logic                  load_in_range;
    logic [IDX_BITS-1:0]   load_addr;
    logic [IDX_BITS-1:0]   rd_addr;
    logic [CNT_BITS-1:0]   cfg_limit;
    logic                  ram_we;
    logic [IDX_BITS-1:0]   ram_waddr;
    logic [SIZE_BITS-1:0]  ram_wdata;
    logic [SIZE_BITS-1:0]  ram_rdata;
    cand_t                 cand;
    logic                  sel_found;
    logic [IDX_BITS-1:0]   sel_best_idx;
    logic                  scan_done;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Load address and its range check against the table depth.
    assign load_addr     = to_addr(s_data.partition_index);
    assign load_in_range = (32'(s_data.partition_index) < PARTITIONS);

    // Number of entries to scan, saturated at the table depth.
    assign cfg_limit = (32'(cfg_reg) > PARTITIONS) ? CNT_BITS'(PARTITIONS)
                                                   : CNT_BITS'(cfg_reg);

    assign rd_addr   = rd_cnt_reg[IDX_BITS-1:0];
    assign scan_done = (rd_cnt_reg == lim_reg) && !cmp_vld_reg;

    // Entry read last cycle; one never written since reset reads as zero.
    assign cand.vld  = cmp_vld_reg;
    assign cand.idx  = cmp_idx_reg;
    assign cand.have = cmp_hit_reg ? ram_rdata : '0;

    bfpa_ram #(
        .WIDTH (SIZE_BITS),
        .DEPTH (PARTITIONS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (ram_rdata)
    );

    bfpa_select u_select (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (accept),
        .cand     (cand),
        .req_size (req_size_reg),
        .found    (sel_found),
        .best_idx (sel_best_idx)
    );

    // Configuration register.
    assign cfg_next = cfg_we ? cfg_wdata : cfg_reg;

    // Sequencer: load or start a scan, scan the table, write back the grant, then deliver.
    always_comb begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        rd_cnt_next   = rd_cnt_reg;
        lim_next      = lim_reg;
        req_size_next = req_size_reg;
        cmp_vld_next  = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        cmp_hit_next  = cmp_hit_reg;
        m_valid_next  = m_valid_reg && !m_ready;
        m_data_next   = m_data_reg;
        ram_we        = 1'b0;
        ram_waddr     = load_addr;
        ram_wdata     = fit_size(s_data.size);

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.func == FUNC_LOAD) begin
                        if (load_in_range) begin
                            ram_we                = 1'b1;
                            valid_next[load_addr] = 1'b1;
                        end
                        state_next = ST_FINISH;
                    end else begin
                        req_size_next = fit_size(s_data.size);
                        lim_next      = cfg_limit;
                        rd_cnt_next   = '0;
                        state_next    = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (rd_cnt_reg != lim_reg) begin
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = rd_addr;
                    cmp_hit_next = valid_reg[rd_addr];
                    rd_cnt_next  = rd_cnt_reg + CNT_BITS'(1);
                end else if (scan_done) begin
                    state_next = sel_found ? ST_GRANT : ST_FINISH;
                end
            end
            ST_GRANT: begin
                // The granted partition is now used: its stored size becomes zero.
                ram_we                   = 1'b1;
                ram_waddr                = sel_best_idx;
                ram_wdata                = '0;
                valid_next[sel_best_idx] = 1'b1;
                state_next               = ST_FINISH;
            end
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.granted     = sel_found;
                    m_data_next.block_index = to_field(sel_best_idx);
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state is reset; scan payload registers are not.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            cfg_reg     <= CFG_RESET;
            valid_reg   <= '0;
            rd_cnt_reg  <= '0;
            lim_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cfg_reg     <= cfg_next;
            valid_reg   <= valid_next;
            rd_cnt_reg  <= rd_cnt_next;
            lim_reg     <= lim_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
        req_size_reg <= req_size_next;
        cmp_idx_reg  <= cmp_idx_next;
        cmp_hit_reg  <= cmp_hit_next;
        m_data_reg   <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ verif/tb_best_fit_partition_allocator.sv @@
// Self-checking testbench for the best-fit partition allocator (best_fit_partition_allocator).
// Depends on bfpa_pkg and the allocator RTL. A behavioural copy of the size table predicts
// every result transaction, and each result is checked in order against that prediction.

module tb_best_fit_partition_allocator;

    import bfpa_pkg::*;

    localparam int IDLE_LIMIT   = 2000;
    localparam int QUIET_ITEMS  = 150;
    localparam int RANDOM_ITEMS = 800;

    logic                aclk;
    logic                aresetn;
    logic                s_valid;
    logic                s_ready;
    in_t                 s_data;
    logic                m_valid;
    logic                m_ready;
    out_t                m_data;
    logic                cfg_we;
    logic [CFG_BITS-1:0] cfg_wdata;

    // Behavioural copy of the allocator state.
    logic [SIZE_BITS-1:0] free_tbl [PARTITIONS];
    logic [CFG_BITS-1:0]  scan_count;

    // Results predicted but not yet seen on the result channel.
    out_t pending_results[$];

    int unsigned err_count;
    int unsigned load_count;
    int unsigned request_count;
    int unsigned grant_count;
    int unsigned setting_count;
    int unsigned idle_cycles;
    bit          quiet;
    int unsigned stall_left;

    best_fit_partition_allocator u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_data   (s_data),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata)
    );

    // Clock with a period of 10 time units.
    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // Best-fit choice over the scanned part of the table; updates the table copy.
    function automatic out_t best_fit_result(in_t t);
        out_t        r;
        int unsigned scan;
        int unsigned have;
        int unsigned best_slack;
        int          best;
        bit          found;
        r          = '0;
        best_slack = 0;
        best       = 0;
        found      = 1'b0;
        if (t.func == FUNC_LOAD) begin
            free_tbl[t.partition_index] = t.size;
            return r;
        end
        scan = (scan_count > PARTITIONS) ? PARTITIONS : scan_count;
        for (int j = 0; j < scan; j++) begin
            have = free_tbl[j];
            if (have >= t.size) begin
                if (!found || (have - t.size) < best_slack) begin
                    found      = 1'b1;
                    best       = j;
                    best_slack = have - t.size;
                end
            end
        end
        if (found) begin
            free_tbl[best]  = '0;
            r.granted       = 1'b1;
            r.block_index   = best[FIELD_IDX_BITS-1:0];
        end
        return r;
    endfunction

    // Sends one transaction, with an occasional gap first, and records its prediction.
    task automatic send_txn(logic func, logic [FIELD_IDX_BITS-1:0] idx,
                            logic [FIELD_SIZE_BITS-1:0] sz);
        in_t  t;
        out_t r;
        t.func            = func;
        t.partition_index = idx;
        t.size            = sz;
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= t;
        do @(posedge aclk); while (!s_ready);
        r = best_fit_result(t);
        pending_results.push_back(r);
        if (func == FUNC_LOAD) begin
            load_count++;
        end else begin
            request_count++;
            if (r.granted) grant_count++;
        end
    endtask

    // Holds the sender off until every outstanding result has been received.
    task automatic wait_drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (2) @(posedge aclk);
    endtask

    // Writes the partition count register while the block is idle.
    task automatic write_scan_count(logic [CFG_BITS-1:0] value);
        wait_drain();
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        scan_count  = value;
        setting_count++;
    endtask

    // Random size with weight on the extremes and on small values.
    function automatic logic [FIELD_SIZE_BITS-1:0] pick_size();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return FIELD_SIZE_BITS'($urandom_range(0, 255));
            default: return FIELD_SIZE_BITS'($urandom);
        endcase
    endfunction

    // Request size drawn near a stored size, so most requests fit somewhere.
    function automatic logic [FIELD_SIZE_BITS-1:0] near_size();
        int unsigned have;
        have = free_tbl[$urandom_range(0, PARTITIONS - 1)];
        case ($urandom_range(0, 3))
            0:       return (have == 32'hFFFF) ? '1 : FIELD_SIZE_BITS'(have + 1);
            1:       return FIELD_SIZE_BITS'(have);
            default: return FIELD_SIZE_BITS'(have - $urandom_range(0, (have < 8) ? have : 8));
        endcase
    endfunction

    // Result channel: compare each transaction with the oldest prediction.
    always @(posedge aclk) begin
        out_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("Result transaction with no prediction waiting: granted=%0d block_index=%0d",
                       m_data.granted, m_data.block_index);
                err_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_data.granted !== exp_r.granted) begin
                    $error("granted: expected %0d, actual %0d", exp_r.granted, m_data.granted);
                    err_count++;
                end
                if (m_data.block_index !== exp_r.block_index) begin
                    $error("block_index: expected %0d, actual %0d",
                           exp_r.block_index, m_data.block_index);
                    err_count++;
                end
            end
        end
    end

    // Receiver back-pressure in bursts of random length, none in the quiet tail.
    always @(negedge aclk) begin
        if (stall_left != 0) begin
            stall_left = stall_left - 1;
            m_ready <= 1'b0;
        end else if (!quiet && $urandom_range(0, 6) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Watchdog: ends the run when no transaction moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Timeout: no transaction for %0d cycles", IDLE_LIMIT);
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Requests against the all-zero table left by reset.
    task automatic test_reset_state();
        // A zero-size request fits an empty entry exactly; the lowest index wins.
        send_txn(FUNC_REQUEST, 4'd0, 16'd0);
        send_txn(FUNC_REQUEST, 4'd15, 16'd0);
        send_txn(FUNC_REQUEST, 4'd0, 16'd1);
        send_txn(FUNC_REQUEST, 4'd9, 16'hFFFF);
    endtask

    // Exact fit, ties, the largest size, ignored index and reuse of a used entry.
    task automatic test_best_fit_rules();
        send_txn(FUNC_LOAD, 4'd15, 16'hFFFF);
        send_txn(FUNC_LOAD, 4'd0, 16'd100);
        send_txn(FUNC_LOAD, 4'd5, 16'd100);
        send_txn(FUNC_LOAD, 4'd7, 16'd40);
        send_txn(FUNC_LOAD, 4'd10, 16'd0);
        // The index field of a request carries no meaning.
        send_txn(FUNC_REQUEST, 4'd15, 16'd40);
        // Equal slack on entries 0 and 5: the lower index is granted first.
        send_txn(FUNC_REQUEST, 4'd5, 16'd90);
        send_txn(FUNC_REQUEST, 4'd0, 16'd90);
        send_txn(FUNC_REQUEST, 4'd0, 16'hFFFF);
        send_txn(FUNC_REQUEST, 4'd0, 16'hFFFF);
        send_txn(FUNC_REQUEST, 4'd0, 16'd1);
        // A used entry holds zero and so matches a zero-size request.
        send_txn(FUNC_REQUEST, 4'd3, 16'd0);
        send_txn(FUNC_LOAD, 4'd15, 16'd0);
        send_txn(FUNC_LOAD, 4'd3, 16'hAAAA);
        send_txn(FUNC_LOAD, 4'd12, 16'h5555);
        send_txn(FUNC_REQUEST, 4'd10, 16'h5555);
        send_txn(FUNC_REQUEST, 4'd5, 16'h5556);
    endtask

    // Scan limits: one entry, none, above the table size, part of it, and back to the full table.
    task automatic test_scan_limits();
        logic [CFG_BITS-1:0] settings [6];
        settings = '{5'd1, 5'd0, 5'd31, 5'd17, 5'd8, 5'd16};
        foreach (settings[k]) begin
            write_scan_count(settings[k]);
            send_txn(FUNC_LOAD, 4'd0, 16'd50);
            send_txn(FUNC_LOAD, 4'd7, 16'd20);
            send_txn(FUNC_LOAD, 4'd8, 16'd10);
            send_txn(FUNC_LOAD, 4'd15, 16'd5);
            send_txn(FUNC_REQUEST, 4'd0, 16'd5);
            send_txn(FUNC_REQUEST, 4'd0, 16'd10);
            send_txn(FUNC_REQUEST, 4'd0, 16'd30);
        end
    endtask

    // Load sequences followed by fitting requests, mixed with noise; a quiet tail ends it.
    task automatic test_random_traffic(int unsigned n_items);
        int unsigned sent;
        int unsigned n_fill;
        int unsigned n_req;
        sent = 0;
        while (sent + QUIET_ITEMS < n_items) begin
            case ($urandom_range(0, 9))
                0:       write_scan_count(5'd0);
                1:       write_scan_count(5'd1);
                2:       write_scan_count(5'd31);
                3, 4:    write_scan_count(5'd16);
                default: write_scan_count(CFG_BITS'($urandom_range(2, 20)));
            endcase
            n_fill = $urandom_range(1, 16);
            n_req  = $urandom_range(1, 12);
            repeat (n_fill) begin
                send_txn(FUNC_LOAD, FIELD_IDX_BITS'($urandom), pick_size());
            end
            repeat (n_req) begin
                if ($urandom_range(0, 3) == 0) begin
                    send_txn(logic'($urandom_range(0, 1)), FIELD_IDX_BITS'($urandom), pick_size());
                end else begin
                    send_txn(FUNC_REQUEST, FIELD_IDX_BITS'($urandom), near_size());
                end
            end
            sent += n_fill + n_req;
        end
        // Tail at full rate: no gaps and no back-pressure.
        quiet = 1'b1;
        repeat (QUIET_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                send_txn(FUNC_LOAD, FIELD_IDX_BITS'($urandom), pick_size());
            end else begin
                send_txn(FUNC_REQUEST, FIELD_IDX_BITS'($urandom), near_size());
            end
        end
    endtask

    // Reset, the tests in turn, then the final check.
    initial begin
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        m_ready       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        err_count     = 0;
        load_count    = 0;
        request_count = 0;
        grant_count   = 0;
        setting_count = 0;
        idle_cycles   = 0;
        stall_left    = 0;
        quiet         = 1'b0;
        scan_count    = CFG_RESET;
        foreach (free_tbl[k]) free_tbl[k] = '0;

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_best_fit_rules();
        test_scan_limits();
        test_random_traffic(RANDOM_ITEMS);

        wait_drain();
        repeat (30) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $error("%0d predicted results never arrived", pending_results.size());
            err_count++;
        end

        $display("Covered %0d loads and %0d requests, %0d of them granted,",
                 load_count, request_count, grant_count);
        $display("across %0d partition count settings including 0, 1, 16 and 31.",
                 setting_count);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
